// ===== rtl/core/gbbn_pkg.sv =====
// Shared constants for the border-normalized Gaussian blur.
// Used by the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gbbn_pkg;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int DIM_W       = 11;
  localparam int RAD_W       = 2;
  localparam int WGT_W       = 16;
  localparam int PIX_W       = 8;
  localparam int GW_W        = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WGT1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WGT2   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WGT3   = 3'd5;

  localparam logic [DIM_W-1:0] RST_WIDTH  = 11'd1024;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 11'd1024;
  localparam logic [RAD_W-1:0] RST_RADIUS = 2'd3;
  localparam logic [WGT_W-1:0] RST_WGT1   = 16'd57835;
  localparam logic [WGT_W-1:0] RST_WGT2   = 16'd39750;
  localparam logic [WGT_W-1:0] RST_WGT3   = 16'd21278;

  localparam logic [GW_W-1:0] G_ONE = 17'h10000;
endpackage
`default_nettype wire

// ===== rtl/core/gbbn_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module gbbn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 6151
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/gaussian_blur_border_normalized_top.sv =====
// Top level of the border-normalized Gaussian blur.
// Depends on gbbn_pkg and gbbn_ram.
//
// Pixels enter on the s_axis channel in raster order; tuser high marks a drain
// item, which flushes one pending output after the last pixel of the image.
// Results leave on m_axis, with tlast on the bottom-right pixel. Registers are
// written through the cfg channel while the block is idle; a write to one of
// the six registers restarts the image and the line store keeps its contents.
// While a register write is offered no input item is taken, and after any
// accepted write the input is held off while the settle flag is set.
// An output trails its input by R*W+R pixels. An item that produces a result
// is accepted, then sweeps its window with reads from the single line store
// read port, drains the pipeline and runs the bit-serial divider; an item
// without a result leaves the block idle. The next item is accepted while a
// result waits in the output register; if the receiver stalls, the divider
// holds its last step until the register frees. After reset all counters are
// zero and the registers take their default values; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module gaussian_blur_border_normalized_top import gbbn_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 3
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,   // pixel
  input  wire logic [0:0]            s_axis_tuser,   // action
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [7:0]            m_axis_tdata,   // blurred
  output logic                       m_axis_tlast,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int LW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int DEPTH = 2 * MAX_RADIUS * (MAX_WIDTH + 1) + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int WT_W  = 2 * GW_W;
  localparam int PR_W  = WT_W + PIX_W;
  localparam int ACC_W = PR_W + 7;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WIN   = 3'd1;
  localparam logic [2:0] ST_FLUSH = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;

  logic [DIM_W-1:0] reg_width, reg_height;
  logic [RAD_W-1:0] reg_radius;
  logic [WGT_W-1:0] reg_w1, reg_w2, reg_w3;
  logic [WW-1:0]    effw;
  logic [HW-1:0]    effh;
  logic [RW-1:0]    effr;
  logic [LW-1:0]    area, lag;
  logic             settle;

  logic [2:0]       state;
  logic [LW-1:0]    in_lin, out_lin;
  logic [HW-1:0]    out_row;
  logic [WW-1:0]    out_col;
  logic [AW-1:0]    wptr, optr;

  logic [HW-1:0]    orow;
  logic [WW-1:0]    ocol;
  logic [AW-1:0]    obase;
  logic [RW-1:0]    rr;
  logic             olast;
  logic signed [RW:0] dy, dx;
  logic             fl_cnt;
  logic [2:0]       div_cnt;
  logic [7:0]       quot;

  logic             v1, v2;
  logic [WT_W-1:0]  wt1;
  logic [PR_W-1:0]  prod2;
  logic [ACC_W-1:0] isum, wsum;
  logic [PIX_W-1:0] rdata;

  function automatic logic [GW_W-1:0] gw(input logic [RW-1:0] d,
                                         input logic [WGT_W-1:0] g1,
                                         input logic [WGT_W-1:0] g2,
                                         input logic [WGT_W-1:0] g3);
    logic [GW_W-1:0] v;
    if (d == '0) v = G_ONE;
    else if (d == RW'(1)) v = {1'b0, g1};
    else if (d == RW'(2)) v = {1'b0, g2};
    else v = {1'b0, g3};
    return v;
  endfunction

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
    return (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
  endfunction

  always_comb begin
    if (reg_width == '0) effw = WW'(1);
    else if (32'(reg_width) > MAX_WIDTH) effw = WW'(MAX_WIDTH);
    else effw = WW'(reg_width);
    if (reg_height == '0) effh = HW'(1);
    else if (32'(reg_height) > MAX_HEIGHT) effh = HW'(MAX_HEIGHT);
    else effh = HW'(reg_height);
    if (32'(reg_radius) > MAX_RADIUS) effr = RW'(MAX_RADIUS);
    else effr = RW'(reg_radius);
  end

  logic idle, s_acc, cfg_acc, cfg_hit;
  assign idle          = (state == ST_IDLE);
  assign s_axis_tready = idle && !settle && !cfg_valid;
  assign cfg_ready     = idle;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign cfg_acc       = cfg_valid && cfg_ready;
  assign cfg_hit       = cfg_acc && (cfg_index <= CFG_WGT3);

  logic            is_drain, in_done, out_done, rs_px, do_write, do_emit;
  logic [LW-1:0]   in_b, out_b, nin;
  logic [HW-1:0]   orow_b;
  logic [WW-1:0]   ocol_b;
  logic [AW-1:0]   wptr_b, optr_b;

  always_comb begin
    is_drain = s_axis_tuser[0];
    in_done  = (in_lin == area);
    out_done = (out_lin == area);
    rs_px    = !is_drain && in_done && out_done;
    do_write = !is_drain && (!in_done || out_done);
    in_b     = rs_px ? '0 : in_lin;
    out_b    = rs_px ? '0 : out_lin;
    orow_b   = rs_px ? '0 : out_row;
    ocol_b   = rs_px ? '0 : out_col;
    wptr_b   = rs_px ? '0 : wptr;
    optr_b   = rs_px ? '0 : optr;
    nin      = in_b + LW'(1);
    if (is_drain) begin
      do_emit = in_done && !out_done;
    end else begin
      do_emit = do_write && (out_b != area) &&
                ((nin == area) || ({1'b0, nin} >= {1'b0, out_b} + {1'b0, lag}));
    end
  end

  logic [AW-1:0]          raddr;
  logic signed [AW+1:0]   off, asum;
  logic signed [HW+1:0]   rowv;
  logic signed [WW+1:0]   colv;
  logic                   in_win;
  logic [RW-1:0]          adx, ady;

  gbbn_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_line_store (
    .clk   (clk),
    .we    (s_acc && do_write),
    .waddr (wptr_b),
    .wdata (s_axis_tdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    off  = (AW+2)'(dy) * $signed((AW+2)'(effw)) + (AW+2)'(dx);
    asum = $signed({2'b0, obase}) + off;
    if (asum < 0) asum = asum + (AW+2)'(DEPTH);
    else if (asum >= (AW+2)'(DEPTH)) asum = asum - (AW+2)'(DEPTH);
    raddr  = AW'(asum);
    rowv   = $signed({2'b0, orow}) + (HW+2)'(dy);
    colv   = $signed({2'b0, ocol}) + (WW+2)'(dx);
    in_win = (rowv >= 0) && (rowv < $signed({2'b0, effh})) &&
             (colv >= 0) && (colv < $signed({2'b0, effw}));
    adx    = RW'(dx < 0 ? -dx : dx);
    ady    = RW'(dy < 0 ? -dy : dy);
  end

  logic [ACC_W-1:0] dshift;
  logic             dfit, dstep;
  assign dshift = wsum << div_cnt;
  assign dfit   = (isum >= dshift);
  assign dstep  = (state == ST_DIV) && ((div_cnt != '0) || !m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_width  <= RST_WIDTH;
      reg_height <= RST_HEIGHT;
      reg_radius <= RST_RADIUS;
      reg_w1     <= RST_WGT1;
      reg_w2     <= RST_WGT2;
      reg_w3     <= RST_WGT3;
      settle     <= 1'b1;
      area       <= '0;
      lag        <= '0;
      state      <= ST_IDLE;
      in_lin     <= '0;
      out_lin    <= '0;
      out_row    <= '0;
      out_col    <= '0;
      wptr       <= '0;
      optr       <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      area   <= LW'(effw) * LW'(effh);
      lag    <= LW'(effr) * LW'(effw) + LW'(effr) + LW'(1);
      settle <= cfg_acc;
      if ((state == ST_DIV) && dstep && (div_cnt == '0)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_hit) begin
        unique case (cfg_index)
          CFG_WIDTH:  reg_width  <= cfg_data[DIM_W-1:0];
          CFG_HEIGHT: reg_height <= cfg_data[DIM_W-1:0];
          CFG_RADIUS: reg_radius <= cfg_data[RAD_W-1:0];
          CFG_WGT1:   reg_w1     <= cfg_data;
          CFG_WGT2:   reg_w2     <= cfg_data;
          CFG_WGT3:   reg_w3     <= cfg_data;
          default:    reg_w3     <= reg_w3;
        endcase
        in_lin  <= '0;
        out_lin <= '0;
        out_row <= '0;
        out_col <= '0;
        wptr    <= '0;
        optr    <= '0;
      end else if (s_acc) begin
        if (do_write) begin
          in_lin  <= nin;
          wptr    <= wrap_inc(wptr_b);
          out_lin <= out_b;
          out_row <= orow_b;
          out_col <= ocol_b;
          optr    <= optr_b;
        end
        if (do_emit) begin
          out_lin <= out_b + LW'(1);
          optr    <= wrap_inc(optr_b);
          if (ocol_b == effw - WW'(1)) begin
            out_col <= '0;
            out_row <= orow_b + HW'(1);
          end else begin
            out_col <= ocol_b + WW'(1);
          end
        end
      end
      v1 <= (state == ST_WIN) && in_win;
      v2 <= v1;
      unique case (state)
        ST_IDLE: begin
          if (!cfg_hit && s_acc && do_emit) state <= ST_WIN;
        end
        ST_WIN: begin
          if (dx == $signed({1'b0, rr}) && dy == $signed({1'b0, rr})) state <= ST_FLUSH;
        end
        ST_FLUSH: begin
          if (fl_cnt) state <= ST_DIV;
        end
        ST_DIV: begin
          if (dstep && div_cnt == '0) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    wt1   <= gw(adx, reg_w1, reg_w2, reg_w3) * gw(ady, reg_w1, reg_w2, reg_w3);
    prod2 <= wt1 * rdata;
    if (s_acc && do_emit) begin
      orow   <= orow_b;
      ocol   <= ocol_b;
      obase  <= optr_b;
      rr     <= effr;
      olast  <= (out_b == area - LW'(1));
      dy     <= -$signed({1'b0, effr});
      dx     <= -$signed({1'b0, effr});
      fl_cnt <= 1'b0;
      div_cnt <= 3'd7;
      quot   <= '0;
      isum   <= '0;
      wsum   <= '0;
    end else begin
      if (state == ST_WIN) begin
        if (dx == $signed({1'b0, rr})) begin
          dx <= -$signed({1'b0, rr});
          dy <= dy + (RW+1)'(1);
        end else begin
          dx <= dx + (RW+1)'(1);
        end
      end
      if (state == ST_FLUSH) fl_cnt <= 1'b1;
      if (v1) wsum <= wsum + ACC_W'(wt1);
      if (v2) isum <= isum + ACC_W'(prod2);
      if (dstep) begin
        if (dfit) begin
          isum <= isum - dshift;
          quot[div_cnt] <= 1'b1;
        end
        div_cnt <= div_cnt - 3'd1;
        if (div_cnt == '0) begin
          m_axis_tdata <= {quot[7:1], dfit};
          m_axis_tlast <= olast;
        end
      end
    end
  end

  a_order: assert property (@(posedge clk) disable iff (rst) out_lin <= in_lin)
    else $error("Output count passed input count.");
  a_ptrs: assert property (@(posedge clk) disable iff (rst)
    (32'(wptr) < DEPTH) && (32'(optr) < DEPTH))
    else $error("Line store pointer out of range.");
  a_div: assert property (@(posedge clk) disable iff (rst) (state == ST_DIV) |-> wsum != '0)
    else $error("Divider started with zero weight sum.");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_axis_tready && !cfg_ready)
    else $error("Input taken while a window is in progress.");
endmodule
`default_nettype wire

// ===== tb/gbbn_checker.sv =====
// Scoreboard for the border-normalized Gaussian blur: watches the cfg, s_axis and m_axis
// channels, predicts every blurred pixel and compares it with what the block gives.
// Depends on gbbn_pkg.
`timescale 1ns / 1ps
module gbbn_checker import gbbn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,
  input  logic [0:0]            s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [7:0]            m_axis_tdata,
  input  logic                  m_axis_tlast,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending_results,
  output int                    result_count
);
  localparam int MAXW = 1024;
  localparam int MAXH = 1024;
  localparam int MAXR = 3;
  localparam int STORE_DEPTH = 2 * MAXR * (MAXW + 1) + 1;

  typedef struct packed {
    logic [7:0] blurred;
    logic       last_pixel;
  } blur_result_t;

  logic [DIM_W-1:0] width_reg, height_reg;
  logic [RAD_W-1:0] radius_reg;
  logic [WGT_W-1:0] wgt1_reg, wgt2_reg, wgt3_reg;
  logic [7:0] rows_seen [STORE_DEPTH];
  int in_col, in_row, out_col, out_row;
  blur_result_t blur_q[$];

  function automatic int eff_w();
    if (width_reg == 0) return 1;
    if (width_reg > MAXW) return MAXW;
    return width_reg;
  endfunction

  function automatic int eff_h();
    if (height_reg == 0) return 1;
    if (height_reg > MAXH) return MAXH;
    return height_reg;
  endfunction

  function automatic int eff_r();
    return (radius_reg > MAXR) ? MAXR : radius_reg;
  endfunction

  function automatic longint unsigned tap_gain(int d);
    if (d < 0) d = -d;
    case (d)
      0: return 64'd65536;
      1: return wgt1_reg;
      2: return wgt2_reg;
      default: return wgt3_reg;
    endcase
  endfunction

  function automatic blur_result_t blur_next();
    blur_result_t res;
    longint unsigned isum, wsum, wt;
    int w, h, r, row, col;
    w = eff_w();
    h = eff_h();
    r = eff_r();
    isum = 0;
    wsum = 0;
    for (int dy = -r; dy <= r; dy++) begin
      row = out_row + dy;
      if (row < 0 || row >= h) continue;
      for (int dx = -r; dx <= r; dx++) begin
        col = out_col + dx;
        if (col < 0 || col >= w) continue;
        wt = tap_gain(dx) * tap_gain(dy);
        wsum += wt;
        isum += wt * rows_seen[(row * w + col) % STORE_DEPTH];
      end
    end
    res.blurred = (wsum != 0) ? 8'(isum / wsum) : 8'd0;
    res.last_pixel = (out_row == h - 1 && out_col == w - 1);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    return res;
  endfunction

  function automatic void take_item(logic drain, logic [7:0] pix);
    int w, h, r, nin, nout;
    w = eff_w();
    h = eff_h();
    r = eff_r();
    if (drain) begin
      if (in_row >= h && out_row < h) blur_q.push_back(blur_next());
      return;
    end
    if (in_row >= h) begin
      if (out_row < h) return;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    end
    rows_seen[(in_row * w + in_col) % STORE_DEPTH] = pix;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    nin = in_row * w + in_col;
    nout = out_row * w + out_col;
    if (out_row < h && (in_row >= h || nin >= nout + r * w + r + 1))
      blur_q.push_back(blur_next());
  endfunction

  always @(posedge clk) begin
    blur_result_t exp_res;
    if (rst) begin
      width_reg = RST_WIDTH;
      height_reg = RST_HEIGHT;
      radius_reg = RST_RADIUS;
      wgt1_reg = RST_WGT1;
      wgt2_reg = RST_WGT2;
      wgt3_reg = RST_WGT3;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      blur_q.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        result_count++;
        if (blur_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("Unexpected result item: blurred=%0d last=%0b", m_axis_tdata, m_axis_tlast);
        end else begin
          exp_res = blur_q.pop_front();
          if (exp_res.blurred !== m_axis_tdata || exp_res.last_pixel !== m_axis_tlast) begin
            fail_count++;
            if (fail_count <= 10)
              $display("Mismatch on result %0d: expected blurred=%0d last=%0b, got %0d %0b",
                       result_count, exp_res.blurred, exp_res.last_pixel,
                       m_axis_tdata, m_axis_tlast);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WIDTH:  width_reg = cfg_data[DIM_W-1:0];
          CFG_HEIGHT: height_reg = cfg_data[DIM_W-1:0];
          CFG_RADIUS: radius_reg = cfg_data[RAD_W-1:0];
          CFG_WGT1:   wgt1_reg = cfg_data;
          CFG_WGT2:   wgt2_reg = cfg_data;
          CFG_WGT3:   wgt3_reg = cfg_data;
          default: ;
        endcase
        if (cfg_index <= CFG_WGT3) begin
          in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        end
      end
      if (s_axis_tvalid && s_axis_tready) take_item(s_axis_tuser[0], s_axis_tdata);
    end
    pending_results = blur_q.size();
  end
endmodule

// ===== tb/tb.sv =====
// Testbench top for the border-normalized Gaussian blur: clock, reset, stimulus and
// verdict. Depends on gbbn_pkg, gbbn_checker and gaussian_blur_border_normalized_top.
`timescale 1ns / 1ps
module tb;
  import gbbn_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int fail_count, pending_results, result_count;
  int cycle = 0;
  int pixels_sent = 0;
  int drains_sent = 0;
  int images_run = 0;
  logic pix_took = 1'b0;
  logic cfg_took = 1'b0;

  always #5 clk = ~clk;

  gaussian_blur_border_normalized_top i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  gbbn_checker i_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_results(pending_results),
    .result_count(result_count)
  );

  wire calm = (cycle >= 10000 && cycle < 25000);

  always @(posedge clk) begin
    cycle <= cycle + 1;
    pix_took <= s_axis_tvalid && s_axis_tready;
    cfg_took <= cfg_valid && cfg_ready;
    if (cycle > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) m_axis_tready <= calm || ($urandom_range(99) >= 12);

  task automatic send_item(logic act, logic [7:0] pix);
    if (!calm && $urandom_range(99) < 12) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = act;
    s_axis_tdata = pix;
    do @(negedge clk); while (!pix_took);
    if (act == ACT_PIXEL) pixels_sent++;
    else drains_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(negedge clk); while (!cfg_took);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (70) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_pixel();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return 8'd0;
    if (roll < 16) return 8'd255;
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] pick_gain();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return 16'd0;
    if (roll < 20) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // Runs one setting: writes all registers, then streams nimg images with drains.
  // With poke set the sender stops halfway through the first image until all results
  // are in and writes the unused register indexes; stop_at cuts the image short.
  task automatic run_setting(int w, int h, int r, logic [15:0] g1, logic [15:0] g2,
                             logic [15:0] g3, int nimg, bit poke, int stop_at);
    int ew, eh, pix, lag, drains;
    wait_idle();
    write_reg(CFG_WIDTH, 16'(w));
    write_reg(CFG_HEIGHT, 16'(h));
    write_reg(CFG_RADIUS, 16'(r));
    write_reg(CFG_WGT1, g1);
    write_reg(CFG_WGT2, g2);
    write_reg(CFG_WGT3, g3);
    ew = (w == 0) ? 1 : (w > 1024 ? 1024 : w);
    eh = (h == 0) ? 1 : (h > 1024 ? 1024 : h);
    pix = ew * eh;
    lag = r * ew + r;
    drains = pix - ((pix - lag > 1) ? pix - lag : 1);
    for (int img = 0; img < nimg; img++) begin
      images_run++;
      for (int p = 0; p < pix; p++) begin
        if (stop_at != 0 && p == stop_at) return;
        if (poke && img == 0 && p == pix / 2) begin
          wait_idle();
          write_reg(CFG_SPARE_A, 16'($urandom));
          write_reg(CFG_SPARE_B, 16'($urandom));
        end
        if ($urandom_range(99) < 4) send_item(ACT_DRAIN, pick_pixel());
        send_item(ACT_PIXEL, pick_pixel());
      end
      for (int d = 0; d < drains; d++) begin
        if ($urandom_range(99) < 5) send_item(ACT_PIXEL, pick_pixel());
        send_item(ACT_DRAIN, pick_pixel());
      end
      repeat ($urandom_range(0, 1)) send_item(ACT_DRAIN, pick_pixel());
    end
  endtask

  initial begin
    int w, h;
    repeat (9) @(negedge clk);
    rst = 1'b0;
    run_setting(1, 1, 3, RST_WGT1, RST_WGT2, RST_WGT3, 1, 0, 0);
    run_setting(0, 0, 0, 16'h1234, 16'h0, 16'hFFFF, 2, 0, 0);
    run_setting(4, 4, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 0);
    run_setting(5, 3, 2, 16'h0, 16'h0, 16'h0, 1, 0, 0);
    run_setting(6, 5, 3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0, 0);
    run_setting(4, 4, 1, 16'h8000, 16'h4000, 16'h2000, 1, 0, 6);
    run_setting(2047, 1, 0, pick_gain(), pick_gain(), pick_gain(), 1, 0, 0);
    run_setting(1, 2047, 3, pick_gain(), pick_gain(), pick_gain(), 1, 0, 300);
    while (pixels_sent < 1650) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 16);
      h = $urandom_range(1, 8);
      run_setting(w, h, $urandom_range(0, 3), pick_gain(), pick_gain(), pick_gain(),
                  $urandom_range(1, 2), $urandom_range(9) == 0, 0);
    end
    wait_idle();
    $display("Covered %0d images: %0d pixel items, %0d drain items, %0d results checked.",
             images_run, pixels_sent, drains_sent, result_count);
    $display("Sizes from 1x1 up to the clamped 1024 width and height, radius 0 to 3, gains 0 to max.");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
